### src/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types, codes and constants of the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

	localparam int SLOT_W        = 4;   // width of slot_index / slot_id
	localparam int ADDR_SLOTS    = 16;  // slots reachable through a 4-bit index
	localparam int CNT_W         = 5;   // holds a count of up to ADDR_SLOTS
	localparam int NUM_SLOTS_DEF = 16;

	localparam logic [31:0] TICK_PERIOD_RST = 32'd1000000;
	localparam logic [63:0] TIME_RST        = 64'd0 - 64'd1000000;

	// request codes
	localparam logic [1:0] REQ_ARM    = 2'd0;
	localparam logic [1:0] REQ_DISARM = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	// result status codes
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_NOT_ARMED = 2'd1;
	localparam logic [1:0] STS_BUSY      = 2'd2;
	localparam logic [1:0] STS_EXPIRED   = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMD,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// one scan beat toward the selection unit
	typedef struct packed {
		logic              start;
		logic              vld;
		logic              armed;
		logic [SLOT_W-1:0] idx;
	} sel_ctl_t;

	// running selection result
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] best_idx;
		logic [CNT_W-1:0]  count;
	} sel_res_t;

	// slots that can be addressed: the smaller of the slot count and ADDR_SLOTS
	function automatic int usable_slots(input int n);
		return (n < ADDR_SLOTS) ? n : ADDR_SLOTS;
	endfunction

endpackage

### src/dtq_slot_mem.sv
// ----------------------------------------------------------------------------
// dtq_slot_mem
// Wake time store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dtq_slot_mem
	import dtq_pkg::*;
#(
	parameter int DEPTH = NUM_SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [63:0]              wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [63:0]              rdata
);

	logic [63:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/dtq_select.sv
// ----------------------------------------------------------------------------
// dtq_select
// Scan datapath: finds the earliest expired slot over one pass of reads.
// ----------------------------------------------------------------------------
module dtq_select
	import dtq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  sel_ctl_t    ctl,
	input  logic [63:0] rdata,
	input  logic [63:0] now,
	output sel_res_t    res
);

	logic              found_q;
	logic [SLOT_W-1:0] best_idx_q;
	logic [CNT_W-1:0]  count_q;
	logic [63:0]       best_q;
	logic              cand;
	logic              better;

	// expired: armed and wake time at or before now
	assign cand   = ctl.vld && ctl.armed && ($signed(rdata) <= $signed(now));
	// ascending scan, strict compare keeps the lowest slot on equal times
	assign better = !found_q || ($signed(rdata) < $signed(best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			best_idx_q <= '0;
			count_q    <= '0;
		end else if (ctl.start) begin
			found_q <= 1'b0;
			count_q <= '0;
		end else if (cand) begin
			found_q <= 1'b1;
			count_q <= count_q + CNT_W'(1);
			if (better) begin
				best_idx_q <= ctl.idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cand && better) begin
			best_q <= rdata;
		end
	end

	assign res.found    = found_q;
	assign res.best_idx = best_idx_q;
	assign res.count    = count_q;

endmodule

### src/deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Timer slots with signed 64-bit wake times, armed, disarmed and expired by tick.
// ----------------------------------------------------------------------------
// Use:
//  - Input channel (in_valid/in_ready): req_type arm, disarm or tick, with
//    slot_index and wake_time. One beat is taken at a time; in_ready is high
//    only while no earlier request is still being worked on.
//  - Output channel (out_valid/out_ready): slot_id, status, time_now, is_last.
//    Arm and disarm give one result; a tick gives one result per expired slot
//    (earliest wake time first, ties by lower slot), or a single ok result.
//    Request type 3 gives no result.
//  - Config channel (cfg_valid/cfg_ready/cfg_data): tick_period, always ready.
// Sequence:
//  - Arm/disarm: the request is latched, the command state loads the result
//    into the output register, then idle takes the next request.
//  - Tick: max(k,1) selection passes for k expiries, each a scan over
//    min(NUM_SLOTS,16) slots (one wake time read per cycle from the slot memory,
//    then the registered read data, then an emit); slots beyond 16 are not
//    addressable. Idle takes the next request after the last emit.
// Reset: all slots free, time at minus the reset period, no clearing pass.
// A stalled receiver holds the output register; the sequencer waits in its
// emit or command state until the register frees up, so nothing is lost.
// ----------------------------------------------------------------------------
module deadline_timer_queue
	import dtq_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          req_type,
	input  logic [SLOT_W-1:0]   slot_index,
	input  logic signed [63:0]  wake_time,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SLOT_W-1:0]   slot_id,
	output logic [1:0]          status,
	output logic signed [63:0]  time_now,
	output logic                is_last,
	// config channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [31:0]         cfg_data
);

	localparam int USABLE = usable_slots(NUM_SLOTS);
	localparam int IDX_W  = $clog2(USABLE);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(USABLE - 1);

	state_t state_q, state_d;

	// registers
	logic [31:0]       period_q;
	logic [63:0]       time_q;
	logic [USABLE-1:0] armed_q;
	logic [1:0]        req_q;
	logic [SLOT_W-1:0] slot_q;
	logic [63:0]       wake_q;

	logic              out_valid_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [1:0]        out_status_q;
	logic [63:0]       out_time_q;
	logic              out_last_q;

	// scan pipeline
	logic              scan_run_q;
	logic [IDX_W-1:0]  scan_addr_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [63:0]       rdata_s1;

	sel_ctl_t sel_ctl;
	sel_res_t sel_res;

	// control
	logic in_acc;
	logic out_free;
	logic cmd_go;
	logic emit_go;
	logic sel_start;
	logic scan_done;

	// command evaluation
	logic             slot_ok;
	logic [IDX_W-1:0] slot_idx;
	logic             slot_hit;
	logic [1:0]       cmd_status;
	logic             cmd_set;
	logic             cmd_clr;
	logic             emit_more;

	// tick time, saturating in the sign-biased domain
	logic [63:0] biased;
	logic [64:0] biased_sum;
	logic [63:0] biased_new;
	logic [63:0] tick_time;

	assign biased     = {~time_q[63], time_q[62:0]};
	assign biased_sum = {1'b0, biased} + {33'b0, period_q};
	assign biased_new = biased_sum[64] ? '1 : biased_sum[63:0];
	assign tick_time  = {~biased_new[63], biased_new[62:0]};

	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign scan_done = vld_s1 && (idx_s1 == LAST_IDX);
	assign emit_more = sel_res.found && (sel_res.count != CNT_W'(1));

	// arm/disarm decode
	assign slot_ok  = ({1'b0, slot_q} < (SLOT_W + 1)'(USABLE));
	assign slot_idx = slot_q[IDX_W-1:0];
	assign slot_hit = slot_ok && armed_q[slot_idx];

	always_comb begin
		cmd_status = STS_NOT_ARMED;
		cmd_set    = 1'b0;
		cmd_clr    = 1'b0;
		if (slot_ok) begin
			if (req_q == REQ_ARM) begin
				cmd_status = slot_hit ? STS_BUSY : STS_OK;
				cmd_set    = !slot_hit;
			end else begin
				cmd_status = slot_hit ? STS_OK : STS_NOT_ARMED;
				cmd_clr    = slot_hit;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (req_type)
						REQ_ARM, REQ_DISARM: state_d = ST_CMD;
						REQ_TICK:            state_d = ST_SCAN;
						default:             state_d = ST_IDLE;
					endcase
				end
			end
			ST_CMD: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_d = emit_more ? ST_SCAN : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		cmd_go    = 1'b0;
		emit_go   = 1'b0;
		sel_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				sel_start = in_valid && (req_type == REQ_TICK);
			end
			ST_CMD: begin
				cmd_go = out_free;
			end
			ST_SCAN: begin
			end
			ST_EMIT: begin
				emit_go   = out_free;
				sel_start = out_free && emit_more;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= TICK_PERIOD_RST;
		end else if (cfg_valid) begin
			period_q <= cfg_data;
		end
	end

	// current time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= TIME_RST;
		end else if (in_acc && (req_type == REQ_TICK)) begin
			time_q <= tick_time;
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q  <= req_type;
			slot_q <= slot_index;
			wake_q <= wake_time;
		end
	end

	// armed bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
		end else if (cmd_go && cmd_set) begin
			armed_q[slot_idx] <= 1'b1;
		end else if (cmd_go && cmd_clr) begin
			armed_q[slot_idx] <= 1'b0;
		end else if (emit_go && sel_res.found) begin
			armed_q[sel_res.best_idx[IDX_W-1:0]] <= 1'b0;
		end
	end

	// scan address and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_run_q  <= 1'b0;
			scan_addr_q <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
		end else begin
			vld_s1 <= scan_run_q;
			idx_s1 <= scan_addr_q;
			if (sel_start) begin
				scan_run_q  <= 1'b1;
				scan_addr_q <= '0;
			end else if (scan_run_q) begin
				if (scan_addr_q == LAST_IDX) begin
					scan_run_q <= 1'b0;
				end else begin
					scan_addr_q <= scan_addr_q + IDX_W'(1);
				end
			end
		end
	end

	dtq_slot_mem #(
		.DEPTH (USABLE)
	) u_mem (
		.clk   (clk),
		.we    (cmd_go && cmd_set),
		.waddr (slot_idx),
		.wdata (wake_q),
		.re    (scan_run_q),
		.raddr (scan_addr_q),
		.rdata (rdata_s1)
	);

	assign sel_ctl.start = sel_start;
	assign sel_ctl.vld   = vld_s1;
	assign sel_ctl.armed = armed_q[idx_s1];
	assign sel_ctl.idx   = SLOT_W'(idx_s1);

	dtq_select u_sel (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sel_ctl),
		.rdata  (rdata_s1),
		.now    (time_q),
		.res    (sel_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_go || emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_go) begin
			out_slot_q   <= slot_q;
			out_status_q <= cmd_status;
			out_time_q   <= time_q;
			out_last_q   <= 1'b1;
		end else if (emit_go) begin
			out_slot_q   <= sel_res.found ? sel_res.best_idx : '0;
			out_status_q <= sel_res.found ? STS_EXPIRED : STS_OK;
			out_time_q   <= time_q;
			out_last_q   <= !emit_more;
		end
	end

	assign out_valid = out_valid_q;
	assign slot_id   = out_slot_q;
	assign status    = out_status_q;
	assign time_now  = out_time_q;
	assign is_last   = out_last_q;

`ifndef ASSERT_OFF
	// an expiry is only ever reported for a slot that is still armed
	a_emit_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && sel_res.found) |-> armed_q[sel_res.best_idx[IDX_W-1:0]])
		else $error("expired slot not armed");

	// selection flag and candidate count agree at the end of a pass
	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (sel_res.found == (sel_res.count != '0)))
		else $error("found flag and count disagree");

	// a tick never moves time backward
	a_time_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (req_type == REQ_TICK)) |=> ($signed(time_q) >= $signed($past(time_q))))
		else $error("time went backward on tick");

	// read data only returns while a scan is in progress
	a_scan_beat: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_SCAN))
		else $error("scan beat outside scan state");
`endif

endmodule

### tb/deadline_timer_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deadline_timer_queue_tb
// Self-checking bench for the timer slot queue. A short table of directed
// requests opens the run. Random arm, disarm and tick traffic follows, under
// several tick periods. Every result beat is checked field by field against a
// behavioral copy of the slot state kept inside the bench.
// ----------------------------------------------------------------------------
module deadline_timer_queue_tb;
	import dtq_pkg::*;

	localparam logic [1:0]  REQ_NONE      = 2'd3;   // unused code, gives no result
	localparam logic [63:0] WAKE_MIN      = 64'h8000_0000_0000_0000;
	localparam logic [63:0] WAKE_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int          IDLE_LIMIT    = 5000;   // cycles with no beat at all
	localparam int          LONG_HOLD     = 300;    // receiver back-pressure stretch
	localparam int          SETTLE_CYCLES = 40;     // covers a request that answers nothing
	localparam int          TAIL_CYCLES   = 400;    // covers a tick that expires all 16 slots
	localparam int          MAX_REPORTS   = 10;

	// one result beat
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [1:0]        sts;
		logic [63:0]       at;
		logic              last;
	} timer_res_t;

	// one directed request; typed rows carry the single result they must give
	typedef struct packed {
		logic [1:0]        req;
		logic [SLOT_W-1:0] slot;
		logic [63:0]       wake;
		logic              typed;
		timer_res_t        res;
	} req_row_t;

	localparam timer_res_t NO_RES = '0;

	// Reset period is 1000000, so time starts at -1000000 and the first
	// tick lands on 0. Slots 3 and 7 share a wake time to exercise the tie
	// order; slot 0 is armed far in the past without expiring until a tick.
	localparam req_row_t DIR_ROWS [16] = '{
		'{REQ_TICK,   4'd0,  64'd0,                  1'b1,
			'{4'd0,  STS_OK,        64'd0,       1'b1}},
		'{REQ_ARM,    4'd0,  WAKE_MIN,               1'b1,
			'{4'd0,  STS_OK,        64'd0,       1'b1}},
		'{REQ_ARM,    4'd0,  64'd5,                  1'b1,
			'{4'd0,  STS_BUSY,      64'd0,       1'b1}},
		'{REQ_DISARM, 4'd5,  64'd0,                  1'b1,
			'{4'd5,  STS_NOT_ARMED, 64'd0,       1'b1}},
		'{REQ_ARM,    4'd15, WAKE_MAX,               1'b1,
			'{4'd15, STS_OK,        64'd0,       1'b1}},
		'{REQ_ARM,    4'd3,  64'd1000000,            1'b1,
			'{4'd3,  STS_OK,        64'd0,       1'b1}},
		'{REQ_ARM,    4'd7,  64'd1000000,            1'b1,
			'{4'd7,  STS_OK,        64'd0,       1'b1}},
		'{REQ_ARM,    4'd1,  64'd999999,             1'b1,
			'{4'd1,  STS_OK,        64'd0,       1'b1}},
		'{REQ_ARM,    4'd9,  64'd2000000,            1'b1,
			'{4'd9,  STS_OK,        64'd0,       1'b1}},
		'{REQ_ARM,    4'd10, 64'h5555_5555_5555_5555, 1'b1,
			'{4'd10, STS_OK,        64'd0,       1'b1}},
		// four expiries: 0, 1, then the 3/7 tie
		'{REQ_TICK,   4'd0,  64'd0,                  1'b0, NO_RES},
		'{REQ_NONE,   4'd15, WAKE_MAX,               1'b0, NO_RES},
		'{REQ_DISARM, 4'd9,  64'd0,                  1'b1,
			'{4'd9,  STS_OK,        64'd1000000, 1'b1}},
		'{REQ_DISARM, 4'd15, 64'd0,                  1'b1,
			'{4'd15, STS_OK,        64'd1000000, 1'b1}},
		'{REQ_TICK,   4'd0,  64'd0,                  1'b1,
			'{4'd0,  STS_OK,        64'd2000000, 1'b1}},
		// slot 0 was freed by its expiry
		'{REQ_DISARM, 4'd0,  64'd0,                  1'b1,
			'{4'd0,  STS_NOT_ARMED, 64'd2000000, 1'b1}}
	};

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          req_type;
	logic [SLOT_W-1:0]   slot_index;
	logic signed [63:0]  wake_time;
	logic                out_valid;
	logic                out_ready;
	logic [SLOT_W-1:0]   slot_id;
	logic [1:0]          status;
	logic signed [63:0]  time_now;
	logic                is_last;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [31:0]         cfg_data;

	// travels with the request payload so the monitor knows a typed row
	logic       row_typed;
	timer_res_t row_res;

	// bench copy of the slot state
	logic [31:0] tm_period;
	longint      tm_now;
	bit          tm_armed [ADDR_SLOTS];
	longint      tm_wake  [ADDR_SLOTS];
	timer_res_t  due_q [$];              // results still owed by the block

	int n_bad;
	int idle_cycles;
	bit quiet;      // final stretch: no gaps on either side
	int hold_reqs;  // long hold-offs asked of the receiver so far

	deadline_timer_queue dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.slot_index (slot_index),
		.wake_time  (wake_time),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.slot_id    (slot_id),
		.status     (status),
		.time_now   (time_now),
		.is_last    (is_last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Slot state update for one accepted request; owed results are queued.
	// A tick saturates the time at the top of the signed range, then
	// expires every armed slot due at or before the new time, earliest
	// wake first and lower slot first on a tie.
	// ------------------------------------------------------------------
	function automatic void advance_timers(input logic [1:0] req,
			input logic [SLOT_W-1:0] slot, input longint wake);
		bit         hit [ADDR_SLOTS];
		int         best;
		int         n_exp;
		logic [1:0] sts;
		longint     step;
		timer_res_t tail;
		if (req == REQ_ARM) begin
			sts = tm_armed[slot] ? STS_BUSY : STS_OK;
			if (!tm_armed[slot]) begin
				tm_armed[slot] = 1'b1;
				tm_wake[slot]  = wake;
			end
			due_q.push_back('{slot, sts, tm_now, 1'b1});
		end else if (req == REQ_DISARM) begin
			sts = tm_armed[slot] ? STS_OK : STS_NOT_ARMED;
			tm_armed[slot] = 1'b0;
			due_q.push_back('{slot, sts, tm_now, 1'b1});
		end else if (req == REQ_TICK) begin
			step = longint'({32'd0, tm_period});
			if (tm_now > longint'(WAKE_MAX) - step)
				tm_now = longint'(WAKE_MAX);
			else
				tm_now = tm_now + step;
			foreach (hit[i])
				hit[i] = tm_armed[i] && (tm_wake[i] <= tm_now);
			n_exp = 0;
			do begin
				best = -1;
				for (int i = 0; i < ADDR_SLOTS; i++)
					if (hit[i] && (best < 0 || tm_wake[i] < tm_wake[best]))
						best = i;
				if (best >= 0) begin
					hit[best]      = 1'b0;
					tm_armed[best] = 1'b0;
					due_q.push_back('{SLOT_W'(best), STS_EXPIRED, tm_now, 1'b0});
					n_exp++;
				end
			end while (best >= 0);
			if (n_exp == 0) begin
				due_q.push_back('{'0, STS_OK, tm_now, 1'b1});
			end else begin
				tail      = due_q.pop_back();
				tail.last = 1'b1;
				due_q.push_back(tail);
			end
		end
	endfunction

	function automatic void note_bad(input string what, input timer_res_t want,
			input timer_res_t got);
		n_bad++;
		if (n_bad <= MAX_REPORTS)
			$display("%0t %s: want slot %0d sts %0d t %0d last %0b, got slot %0d sts %0d t %0d last %0b",
				$realtime, what, want.slot, want.sts, $signed(want.at), want.last,
				got.slot, got.sts, $signed(got.at), got.last);
	endfunction

	// ------------------------------------------------------------------
	// Monitor: sampled at the rising edge, so it sees the values that the
	// edge itself saw. Request beats feed the slot model, config beats
	// the period, result beats are checked against the oldest owed one.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : mon
		timer_res_t got;
		timer_res_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				advance_timers(req_type, slot_index, wake_time);
				if (row_typed && req_type != REQ_NONE) begin
					void'(due_q.pop_back());
					due_q.push_back(row_res);
				end
			end
			if (cfg_valid && cfg_ready)
				tm_period = cfg_data;
			if (out_valid && out_ready) begin
				got = '{slot_id, status, time_now, is_last};
				if (due_q.size() == 0) begin
					note_bad("result beat with nothing owed", NO_RES, got);
				end else begin
					want = due_q.pop_front();
					if (got.slot !== want.slot || got.sts !== want.sts ||
							got.at !== want.at || got.last !== want.last)
						note_bad("result mismatch", want, got);
				end
			end
		end
	end

	// Watchdog: any beat on any channel restarts the count.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: random stall bursts, one long hold-off per request, none in
	// the quiet stretch. One assignment to out_ready per edge.
	// ------------------------------------------------------------------
	initial begin : rx
		int hold_seen;
		hold_seen = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				out_ready <= 1'b0;
				for (int n = 0; n < LONG_HOLD; n++)
					@(posedge clk);
				out_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side. Tasks start and end on a rising edge; valid only drops
	// on a gap or a drain, never between back-to-back beats.
	// ------------------------------------------------------------------
	task automatic send_req(input logic [1:0] req, input logic [SLOT_W-1:0] slot,
			input logic [63:0] wake, input logic typed, input timer_res_t res);
		in_valid   <= 1'b1;
		req_type   <= req;
		slot_index <= slot;
		wake_time  <= wake;
		row_typed  <= typed;
		row_res    <= res;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every owed result has arrived.
	// The first edge lets the monitor log the last accepted request.
	task automatic drain(input int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_q.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_period(input logic [31:0] period);
		drain(SETTLE_CYCLES);
		cfg_valid <= 1'b1;
		cfg_data  <= period;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly a slot in the wanted state, so arms and disarms take effect.
	function automatic logic [SLOT_W-1:0] pick_slot(input bit want_armed);
		logic [SLOT_W-1:0] s;
		s = SLOT_W'($urandom_range(0, ADDR_SLOTS - 1));
		if ($urandom_range(0, 3) != 0)
			for (int n = 0; n < 16 && tm_armed[s] != want_armed; n++)
				s = SLOT_W'($urandom_range(0, ADDR_SLOTS - 1));
		return s;
	endfunction

	// Mostly within a few periods of now so expiries really happen.
	function automatic logic [63:0] pick_wake();
		int     r;
		longint off;
		r = $urandom_range(0, 9);
		if (r == 0)
			return $urandom_range(0, 1) ? WAKE_MAX : WAKE_MIN;
		if (r < 3)
			return {$urandom, $urandom};
		off = longint'($urandom_range(0, 6)) - 2;
		return tm_now + off * longint'({32'd0, tm_period}) +
			longint'($urandom_range(0, 2)) - 1;
	endfunction

	task automatic run_random(input int n_items, input bit with_hold, input bit with_pause);
		int          done_cnt;
		int          r;
		bit          held;
		bit          paused;
		logic [63:0] w;
		done_cnt = 0;
		held     = 1'b0;
		paused   = 1'b0;
		while (done_cnt < n_items) begin
			if (with_hold && !held && done_cnt >= n_items / 3) begin
				held = 1'b1;
				hold_reqs++;   // sender keeps offering, block backs up
			end
			if (with_pause && !paused && done_cnt >= 2 * n_items / 3) begin
				paused = 1'b1;
				drain(0);
			end
			r = $urandom_range(0, 99);
			if (r < 5) begin
				// fill every free slot with one wake time, then expire them
				w = tm_now + longint'($urandom_range(0, 1)) * longint'({32'd0, tm_period});
				for (int s = 0; s < ADDR_SLOTS; s++)
					if (!tm_armed[s]) begin
						send_req(REQ_ARM, SLOT_W'(s), w, 1'b0, NO_RES);
						done_cnt++;
					end
				send_req(REQ_TICK, SLOT_W'($urandom), {$urandom, $urandom}, 1'b0, NO_RES);
				done_cnt++;
			end else if (r < 50) begin
				send_req(REQ_ARM, pick_slot(1'b0), pick_wake(), 1'b0, NO_RES);
				done_cnt++;
			end else if (r < 65) begin
				send_req(REQ_DISARM, pick_slot(1'b1), {$urandom, $urandom}, 1'b0, NO_RES);
				done_cnt++;
			end else if (r < 95) begin
				send_req(REQ_TICK, SLOT_W'($urandom), {$urandom, $urandom}, 1'b0, NO_RES);
				done_cnt++;
			end else begin
				// ignored by the block, not counted
				send_req(REQ_NONE, SLOT_W'($urandom), {$urandom, $urandom}, 1'b0, NO_RES);
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		req_type   = REQ_ARM;
		slot_index = '0;
		wake_time  = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		row_typed  = 1'b0;
		row_res    = NO_RES;
		quiet      = 1'b0;
		hold_reqs  = 0;
		n_bad      = 0;
		tm_period  = TICK_PERIOD_RST;
		tm_now     = longint'(TIME_RST);
		foreach (tm_armed[i]) begin
			tm_armed[i] = 1'b0;
			tm_wake[i]  = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[k])
			send_req(DIR_ROWS[k].req, DIR_ROWS[k].slot, DIR_ROWS[k].wake,
				DIR_ROWS[k].typed, DIR_ROWS[k].res);

		// reset period, then both extremes, then a random one
		run_random(60, 1'b1, 1'b1);
		write_period(32'd1);
		run_random(60, 1'b0, 1'b1);
		write_period(32'hFFFF_FFFF);
		run_random(60, 1'b1, 1'b0);
		write_period(32'($urandom_range(2, 5000)));
		quiet = 1'b1;
		run_random(64, 1'b0, 1'b0);

		drain(TAIL_CYCLES);
		if (due_q.size() != 0)
			note_bad("result never arrived", due_q[0], NO_RES);
		if (n_bad == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### sim.f
src/dtq_pkg.sv
src/dtq_slot_mem.sv
src/dtq_select.sv
src/deadline_timer_queue.sv
tb/deadline_timer_queue_tb.sv
